// ===== src/rrwc_pkg.sv =====
// ============================================================================
// rrwc_pkg
// Shared types, widths and helper functions of the rotated rectangle clipper.
// ============================================================================
`default_nettype none

package rrwc_pkg;

  localparam int COORD_W  = 20;   // port coordinates, signed Q15.4
  localparam int SIZE_W   = 19;   // full sizes, unsigned Q15.4
  localparam int TRIG_W   = 16;   // cosine and sine, signed Q1.14
  localparam int CW       = 22;   // internal vertex coordinates
  localparam int PROD_W   = 36;   // half size times cosine or sine
  localparam int SUM_W    = 37;   // sum of two such products
  localparam int OFS_W    = 23;   // rounded rotated offset
  localparam int NUM_W    = 48;   // intersection numerator
  localparam int DEN_W    = 24;   // intersection denominator
  localparam int QUO_W    = 24;   // intersection quotient magnitude
  localparam int CLIP_CAP = 32;   // vertex slots of one buffer bank
  localparam int ADDR_W   = $clog2(CLIP_CAP);
  localparam int CNT_W    = $clog2(CLIP_CAP + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_VERTICES_DEF = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_MIN_X = 2'd0,
    REG_WIN_MIN_Y = 2'd1,
    REG_WIN_MAX_X = 2'd2,
    REG_WIN_MAX_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } window_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vertex_t;

  typedef struct packed {
    vertex_t [3:0]             corner;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } qentry_t;

  // Divide by 2^15, rounding to nearest with ties away from zero.
  function automatic logic signed [OFS_W-1:0] rnd15(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q;
    logic [OFS_W-1:0] qs;
    mag = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
    q   = (mag + SUM_W'(16384)) >> 15;
    qs  = q[OFS_W-1:0];
    return v[SUM_W-1] ? $signed(~qs + OFS_W'(1)) : $signed(qs);
  endfunction

  // Saturate an internal coordinate to the port range.
  function automatic logic [COORD_W-1:0] sat20(input logic signed [CW-1:0] v);
    logic [COORD_W-1:0] res;
    if (!v[CW-1] && (v[CW-2:COORD_W-1] != '0)) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v[CW-1] && (v[CW-2:COORD_W-1] != '1)) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/rrwc_ifs.sv =====
// ============================================================================
// rrwc channel interfaces
// Valid/ready channels for rectangles, vertices and register writes.
// ============================================================================
`default_nettype none

interface rrwc_in_if;
  import rrwc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [SIZE_W-1:0]         size_x;
  logic [SIZE_W-1:0]         size_y;
  logic signed [TRIG_W-1:0]  cos_angle;
  logic signed [TRIG_W-1:0]  sin_angle;
  modport source (output valid, center_x, center_y, size_x, size_y, cos_angle, sin_angle,
                  input ready);
  modport sink   (input valid, center_x, center_y, size_x, size_y, cos_angle, sin_angle,
                  output ready);
endinterface

interface rrwc_out_if;
  import rrwc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      is_marker;
  logic                      last_vertex;
  modport source (output valid, vertex_x, vertex_y, is_marker, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, is_marker, last_vertex, output ready);
endinterface

interface rrwc_cfg_if;
  import rrwc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rrwc_front.sv =====
// ============================================================================
// rrwc_front
// Rotates the four rectangle corners about the center and queues them.
// ============================================================================
`default_nettype none

module rrwc_front (
  input  logic             clk,
  input  logic             rst_n,
  rrwc_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output rrwc_pkg::qentry_t q_entry
);
  import rrwc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_RND, F_PUSH} fstate_t;

  fstate_t state_r;
  logic signed [PROD_W-1:0] a_r, b_r, c_r, d_r;
  logic signed [OFS_W-1:0]  p_r, q_r, r_r, t_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic signed [SIZE_W:0]   hx_s, hy_s;
  logic signed [PROD_W-1:0] mul_a, mul_b, mul_c, mul_d;

  function automatic logic signed [CW-1:0] place(input logic signed [COORD_W-1:0] c,
                                                 input logic signed [OFS_W-1:0] o,
                                                 input logic neg);
    logic signed [OFS_W:0] ce;
    logic signed [OFS_W:0] oe;
    logic signed [OFS_W:0] s;
    ce = {{(OFS_W+1-COORD_W){c[COORD_W-1]}}, c};
    oe = {o[OFS_W-1], o};
    s  = neg ? (ce - oe) : (ce + oe);
    return s[CW-1:0];
  endfunction

  assign hx_s  = $signed({1'b0, in_ch.size_x});
  assign hy_s  = $signed({1'b0, in_ch.size_y});
  assign mul_a = hx_s * in_ch.cos_angle;
  assign mul_b = hy_s * in_ch.sin_angle;
  assign mul_c = hx_s * in_ch.sin_angle;
  assign mul_d = hy_s * in_ch.cos_angle;

  assign in_ch.ready = (state_r == F_IDLE);
  assign q_push      = (state_r == F_PUSH) && !q_full;

  // Opposite corners use the same rounded offset with opposite sign.
  always_comb begin
    q_entry.cx = cx_r;
    q_entry.cy = cy_r;
    q_entry.corner[0].x = place(cx_r, q_r, 1'b1);
    q_entry.corner[0].y = place(cy_r, r_r, 1'b1);
    q_entry.corner[1].x = place(cx_r, p_r, 1'b0);
    q_entry.corner[1].y = place(cy_r, t_r, 1'b0);
    q_entry.corner[2].x = place(cx_r, q_r, 1'b0);
    q_entry.corner[2].y = place(cy_r, r_r, 1'b0);
    q_entry.corner[3].x = place(cx_r, p_r, 1'b1);
    q_entry.corner[3].y = place(cy_r, t_r, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            a_r  <= mul_a;
            b_r  <= mul_b;
            c_r  <= mul_c;
            d_r  <= mul_d;
            cx_r <= in_ch.center_x;
            cy_r <= in_ch.center_y;
            state_r <= F_RND;
          end
        end
        F_RND: begin
          p_r <= rnd15({a_r[PROD_W-1], a_r} + {b_r[PROD_W-1], b_r});
          q_r <= rnd15({a_r[PROD_W-1], a_r} - {b_r[PROD_W-1], b_r});
          r_r <= rnd15({c_r[PROD_W-1], c_r} + {d_r[PROD_W-1], d_r});
          t_r <= rnd15({c_r[PROD_W-1], c_r} - {d_r[PROD_W-1], d_r});
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rrwc_queue.sv =====
// ============================================================================
// rrwc_queue
// Short FIFO of rotated rectangles between the front and the clip engine.
// ============================================================================
`default_nettype none

module rrwc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrwc_pkg::qentry_t entry_in,
  output logic              full,
  output logic              valid,
  input  logic              pop,
  output rrwc_pkg::qentry_t entry_out
);
  import rrwc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qentry_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;
  logic do_push, do_pop;

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid     = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;
  assign entry_out = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rrwc_div.sv =====
// ============================================================================
// rrwc_div
// Radix-2 restoring divider, rounded to nearest with ties away from zero.
// ============================================================================
`default_nettype none

module rrwc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [rrwc_pkg::NUM_W-1:0] num,
  input  logic signed [rrwc_pkg::DEN_W-1:0] den,
  output logic                              done,
  output logic signed [rrwc_pkg::QUO_W:0]   quot
);
  import rrwc_pkg::*;

  localparam int ITER_W = $clog2(QUO_W);

  logic [NUM_W-1:0] an, n2;
  logic [DEN_W-1:0] ad, d2_in;
  logic [DEN_W-1:0] d2_r, rem_r;
  logic [QUO_W-1:0] nlo_r, q_r;
  logic [DEN_W:0]   trial;
  logic             neg_r, busy_r, done_r;
  logic [ITER_W-1:0] cnt_r;

  // The rounded quotient is floor((2|n| + |d|) / (2|d|)). It is known to be
  // below 2^QUO_W, so the upper half of the dividend starts as the remainder.
  assign an    = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign ad    = den[DEN_W-1] ? (~den + DEN_W'(1)) : den;
  assign n2    = {an[NUM_W-2:0], 1'b0} + {{(NUM_W-DEN_W){1'b0}}, ad};
  assign d2_in = {ad[DEN_W-2:0], 1'b0};
  assign trial = {rem_r, nlo_r[QUO_W-1]} - {1'b0, d2_r};

  assign done = done_r;
  assign quot = neg_r ? $signed(~{1'b0, q_r} + (QUO_W+1)'(1)) : $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITER_W'(QUO_W-1);
        rem_r  <= n2[NUM_W-1:QUO_W];
        nlo_r  <= n2[QUO_W-1:0];
        d2_r   <= d2_in;
        q_r    <= '0;
        neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy_r) begin
        if (!trial[DEN_W]) begin
          rem_r <= trial[DEN_W-1:0];
        end else begin
          rem_r <= {rem_r[DEN_W-2:0], nlo_r[QUO_W-1]};
        end
        q_r   <= {q_r[QUO_W-2:0], !trial[DEN_W]};
        nlo_r <= {nlo_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rrwc_back.sv =====
// ============================================================================
// rrwc_back
// Clip engine: four Sutherland-Hodgman passes over a banked vertex memory,
// then emission of the surviving vertices or of the clamped center.
// ============================================================================
`default_nettype none

module rrwc_back #(
  parameter int MAX_VERTICES = rrwc_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrwc_pkg::window_t win,
  input  logic              q_valid,
  output logic              q_pop,
  input  rrwc_pkg::qentry_t q_data,
  rrwc_out_if.source        out_ch
);
  import rrwc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_PSTART, B_PREV, B_CEVAL, B_DSTART, B_DWAIT,
    B_PUSHC, B_NEXT, B_PDONE, B_ESEND, B_MARK
  } bstate_t;

  bstate_t state_r;
  qentry_t entry_r;
  vertex_t vmem [2*CLIP_CAP];
  vertex_t rdata_r, prev_r, cur_r, wdata, xvert;
  logic [ADDR_W:0] raddr, waddr;
  logic            we;

  logic [CNT_W-1:0] n_r, k_r, i_r, e_r, lim, i_inc, e_inc;
  logic [1:0]       ld_r, pass_r;
  logic             cin_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [CW-1:0]    po_r;

  logic                   div_start, div_done;
  logic signed [QUO_W:0]  div_q;

  logic                      out_valid_r, out_marker_r, out_last_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      emit;

  // Per-pass clip line and inside direction.
  logic                   axis_y, cin, pin, room, out_free;
  logic signed [CW-1:0]   bound, ca, co, pa, po, other;
  logic signed [COORD_W:0] sdir;
  logic signed [CW:0]     dc, dp, diff_o, diff_b, diff_c;
  logic signed [2*CW+1:0] prod;
  logic signed [CW+2:0]   osum;
  logic signed [COORD_W-1:0] mx, my;

  function automatic logic signed [COORD_W:0] wdiff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  always_comb begin
    axis_y = !pass_r[0];
    case (pass_r)
      2'd0: begin
        bound = CW'(win.min_y);
        sdir  = wdiff(win.max_x, win.min_x);
      end
      2'd1: begin
        bound = CW'(win.max_x);
        sdir  = wdiff(win.min_y, win.max_y);
      end
      2'd2: begin
        bound = CW'(win.max_y);
        sdir  = wdiff(win.min_x, win.max_x);
      end
      default: begin
        bound = CW'(win.min_x);
        sdir  = wdiff(win.max_y, win.min_y);
      end
    endcase
    ca = axis_y ? rdata_r.y : rdata_r.x;
    co = axis_y ? rdata_r.x : rdata_r.y;
    pa = axis_y ? prev_r.y  : prev_r.x;
    po = axis_y ? prev_r.x  : prev_r.y;
    dc = {ca[CW-1], ca} - {bound[CW-1], bound};
    dp = {pa[CW-1], pa} - {bound[CW-1], bound};
    // Only the sign of the cross product matters.
    cin = (sdir == '0) || (dc == '0) || (sdir[COORD_W] == dc[CW]);
    pin = (sdir == '0) || (dp == '0) || (sdir[COORD_W] == dp[CW]);
    diff_o = {co[CW-1], co} - {po[CW-1], po};
    diff_b = {bound[CW-1], bound} - {pa[CW-1], pa};
    diff_c = {ca[CW-1], ca} - {pa[CW-1], pa};
    prod   = diff_o * diff_b;
    osum   = {{3{po_r[CW-1]}}, po_r} + {{(CW+2-QUO_W){div_q[QUO_W]}}, div_q};
    other  = osum[CW-1:0];
    if (axis_y) begin
      xvert.x = other;
      xvert.y = bound;
    end else begin
      xvert.x = bound;
      xvert.y = other;
    end
  end

  // Marker: the center clamped to the window, low bound tested first.
  always_comb begin
    if (entry_r.cx < win.min_x) begin
      mx = win.min_x;
    end else if (entry_r.cx > win.max_x) begin
      mx = win.max_x;
    end else begin
      mx = entry_r.cx;
    end
    if (entry_r.cy < win.min_y) begin
      my = win.min_y;
    end else if (entry_r.cy > win.max_y) begin
      my = win.max_y;
    end else begin
      my = entry_r.cy;
    end
  end

  assign room     = (k_r < CNT_W'(CLIP_CAP));
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = out_free && ((state_r == B_ESEND) || (state_r == B_MARK));
  assign lim      = (n_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : n_r;
  assign i_inc    = i_r + CNT_W'(1);
  assign e_inc    = e_r + CNT_W'(1);

  always_comb begin
    we        = 1'b0;
    waddr     = {!pass_r[0], k_r[ADDR_W-1:0]};
    wdata     = cur_r;
    raddr     = {pass_r[0], i_r[ADDR_W-1:0]};
    div_start = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE:   q_pop = q_valid;
      B_LOAD: begin
        we    = 1'b1;
        waddr = {1'b0, ADDR_W'(ld_r)};
        wdata = entry_r.corner[ld_r];
      end
      B_PSTART: raddr = {pass_r[0], ADDR_W'(n_r - CNT_W'(1))};
      B_DSTART: div_start = 1'b1;
      B_DWAIT: begin
        we    = div_done && room;
        wdata = xvert;
      end
      B_PUSHC:  we = room;
      B_NEXT:   raddr = {pass_r[0], i_inc[ADDR_W-1:0]};
      B_PDONE:  raddr = '0;
      B_ESEND: begin
        raddr = {1'b0, (out_free ? e_inc[ADDR_W-1:0] : e_r[ADDR_W-1:0])};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[waddr] <= wdata;
    end
    rdata_r <= vmem[raddr];
  end

  rrwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      i_r         <= '0;
      e_r         <= '0;
      ld_r        <= '0;
      pass_r      <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            entry_r <= q_data;
            ld_r    <= '0;
            state_r <= B_LOAD;
          end
        end
        B_LOAD: begin
          ld_r <= ld_r + 2'd1;
          if (ld_r == 2'd3) begin
            n_r     <= CNT_W'(4);
            pass_r  <= '0;
            state_r <= B_PSTART;
          end
        end
        B_PSTART: begin
          k_r <= '0;
          i_r <= '0;
          state_r <= (n_r == '0) ? B_PDONE : B_PREV;
        end
        B_PREV: begin
          prev_r  <= rdata_r;
          state_r <= B_CEVAL;
        end
        B_CEVAL: begin
          cur_r <= rdata_r;
          cin_r <= cin;
          num_r <= {{(NUM_W-2*CW-2){prod[2*CW+1]}}, prod};
          den_r <= {diff_c[CW], diff_c};
          po_r  <= po;
          if (cin != pin) begin
            state_r <= B_DSTART;
          end else if (cin) begin
            state_r <= B_PUSHC;
          end else begin
            state_r <= B_NEXT;
          end
        end
        B_DSTART: state_r <= B_DWAIT;
        B_DWAIT: begin
          if (div_done) begin
            if (room) begin
              k_r <= k_r + CNT_W'(1);
            end
            state_r <= cin_r ? B_PUSHC : B_NEXT;
          end
        end
        B_PUSHC: begin
          if (room) begin
            k_r <= k_r + CNT_W'(1);
          end
          state_r <= B_NEXT;
        end
        B_NEXT: begin
          prev_r <= cur_r;
          i_r    <= i_inc;
          state_r <= (i_inc == n_r) ? B_PDONE : B_CEVAL;
        end
        B_PDONE: begin
          n_r    <= k_r;
          pass_r <= pass_r + 2'd1;
          e_r    <= '0;
          if (pass_r == 2'd3) begin
            state_r <= (k_r == '0) ? B_MARK : B_ESEND;
          end else begin
            state_r <= B_PSTART;
          end
        end
        B_ESEND: begin
          if (out_free) begin
            out_x_r      <= sat20(rdata_r.x);
            out_y_r      <= sat20(rdata_r.y);
            out_marker_r <= 1'b0;
            out_last_r   <= (e_inc == lim);
            e_r          <= e_inc;
            if (e_inc == lim) begin
              state_r <= B_IDLE;
            end
          end
        end
        B_MARK: begin
          if (out_free) begin
            out_x_r      <= mx;
            out_y_r      <= my;
            out_marker_r <= 1'b1;
            out_last_r   <= 1'b1;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_x    = out_x_r;
  assign out_ch.vertex_y    = out_y_r;
  assign out_ch.is_marker   = out_marker_r;
  assign out_ch.last_vertex = out_last_r;

  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r <= CNT_W'(CLIP_CAP)) && (k_r <= CNT_W'(CLIP_CAP)))
    else $error("vertex count exceeds buffer capacity");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (den_r != '0))
    else $error("intersection started with a zero denominator");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_marker_r) |-> out_last_r)
    else $error("marker word not flagged as last");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ESEND) |-> (n_r != '0))
    else $error("vertex emission with an empty polygon");

endmodule

`default_nettype wire

// ===== src/rotated_rect_window_clipper_unit.sv =====
// ============================================================================
// rotated_rect_window_clipper_unit
// Rotated rectangle clipped against a configurable window.
// ============================================================================
// Each input word describes a rectangle; the unit rotates its corners, clips
// the quadrilateral against the window's top, right, bottom and left edges
// and returns the surviving vertices, at most MAX_VERTICES words with the last
// one flagged, or one marker word holding the clamped center. The front takes
// a rectangle and pushes it into a two-entry queue before it takes the next
// one. The clip engine sets the throughput: it takes a rectangle from the
// queue, loads its four corners, runs four passes over the vertices with a
// bit-serial intersection divide for each edge crossing, then sends one result
// word per cycle while the output is not stalled, and only then takes the next
// rectangle. Window registers are written through the cfg port, which is
// always ready.
`default_nettype none

module rotated_rect_window_clipper_unit #(
  parameter int MAX_VERTICES = rrwc_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rrwc_in_if.sink    in_ch,
  rrwc_out_if.source out_ch,
  rrwc_cfg_if.sink   cfg_ch
);
  import rrwc_pkg::*;

  window_t win_r;
  qentry_t q_in, q_out;
  logic    q_push, q_full, q_valid, q_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_WIN_MIN_X: win_r.min_x <= cfg_ch.data;
        REG_WIN_MIN_Y: win_r.min_y <= cfg_ch.data;
        REG_WIN_MAX_X: win_r.max_x <= cfg_ch.data;
        REG_WIN_MAX_Y: win_r.max_y <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  rrwc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  rrwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .entry_out (q_out)
  );

  rrwc_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
